>>> hdl/bmf_pkg.sv
// Box mean filter package: shared constants, register indexes and pipeline types.
// No dependencies; compiled first.
`default_nettype none

package bmf_pkg;

    localparam int DEF_WINDOW_SIZE = 5;
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT      = 4096;
    localparam int RESET_DIM       = 256;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;
    localparam int OUT_COL_W  = 10;
    localparam int OUT_ROW_W  = 12;
    localparam int PIX_W      = 24;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] rgb_t;

    // per-pixel control carried down the pipeline
    typedef struct packed {
        logic                 int_v;
        logic                 brd_v;
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
        rgb_t                 pix;
    } bmf_meta_t;

endpackage

`default_nettype wire

>>> hdl/bmf_if.sv
// Stream interfaces for the box mean filter: pixel input and result output.
// Depends on nothing; valid/ready handshake, transfer when both are high.
`default_nettype none

interface bmf_pix_if;
    logic       valid;
    logic       ready;
    logic       frame_start;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, frame_start, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, frame_start, red_in, green_in, blue_in, output ready);
endinterface

interface bmf_res_if;
    logic        valid;
    logic        ready;
    logic [9:0]  out_column;
    logic [11:0] out_row;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic        last_of_run;

    modport source (output valid, out_column, out_row, red_out, green_out, blue_out,
                    last_of_run, input ready);
    modport sink   (input valid, out_column, out_row, red_out, green_out, blue_out,
                    last_of_run, output ready);
endinterface

`default_nettype wire

>>> hdl/bmf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read and read enable.
// No dependencies; used for the line stores.
`default_nettype none

module bmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/bmf_lane.sv
// One color channel lane: column sums, window total and reciprocal divide.
// Depends on bmf_pkg for defaults.
`default_nettype none

module bmf_lane #(
    parameter int WINDOW_SIZE = bmf_pkg::DEF_WINDOW_SIZE,
    localparam int SPAN       = 2 * (WINDOW_SIZE / 2) + 1
) (
    input  wire logic                 clk,
    input  wire logic                 adv,
    input  wire logic                 shift,
    input  wire logic [SPAN-1:0][7:0] column,
    output logic      [7:0]           mean
);
    import bmf_pkg::*;

    localparam int AREA = WINDOW_SIZE * WINDOW_SIZE;
    localparam int CSW  = 8 + $clog2(SPAN);
    localparam int SUMW = 8 + $clog2(SPAN * SPAN);
    localparam int SH   = SUMW + 7;
    localparam int MW   = SH - $clog2(AREA) + 1;
    localparam int PW   = SUMW + MW;
    localparam int QW   = PW - SH;
    localparam logic [MW-1:0] RECIP = MW'((2 ** SH + AREA - 1) / AREA);

    logic [SPAN-1:0][CSW-1:0] colsum_reg;
    logic [CSW-1:0]           colsum_next;
    logic [SUMW-1:0]          total_reg;
    logic [SUMW-1:0]          total_next;
    logic [PW-1:0]            prod;
    logic [QW-1:0]            quot;
    logic [7:0]               mean_reg;
    logic [7:0]               mean_next;

    always_comb
    begin
        colsum_next = '0;
        for (int k = 0; k < SPAN; k++)
        begin
            colsum_next = colsum_next + CSW'(column[k]);
        end
        total_next = '0;
        for (int k = 0; k < SPAN; k++)
        begin
            total_next = total_next + SUMW'(colsum_reg[k]);
        end
    end

    // exact floor(total / AREA) for every total that fits SUMW bits
    assign prod = PW'(total_reg) * PW'(RECIP);
    assign quot = prod[PW-1:SH];

    always_comb
    begin
        if (quot > QW'(255))
        begin
            mean_next = 8'hFF;
        end
        else
        begin
            mean_next = quot[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            for (int k = 0; k < SPAN - 1; k++)
            begin
                colsum_reg[k] <= colsum_reg[k+1];
            end
            colsum_reg[SPAN-1] <= colsum_next;
        end
        if (adv)
        begin
            total_reg <= total_next;
            mean_reg  <= mean_next;
        end
    end

    assign mean = mean_reg;

endmodule

`default_nettype wire

>>> hdl/bmf_out.sv
// Merge stage: joins the lane means with pixel control, sends up to two results.
// Depends on bmf_pkg and bmf_res_if; drives the pipeline advance.
`default_nettype none

module bmf_out #(
    parameter int WINDOW_SIZE = bmf_pkg::DEF_WINDOW_SIZE
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bmf_pkg::bmf_meta_t meta,
    input  wire logic              meta_valid,
    input  wire bmf_pkg::rgb_t     mean_rgb,
    output logic                   adv,
    bmf_res_if.source              result
);
    import bmf_pkg::*;

    localparam int HALF = WINDOW_SIZE / 2;

    logic      o_valid_reg;
    logic      sent_reg;
    bmf_meta_t o_meta_reg;
    logic      int_first;
    logic      last;
    rgb_t      rgb;

    assign int_first = o_meta_reg.int_v && !sent_reg;
    assign last      = !(int_first && o_meta_reg.brd_v);
    assign adv       = !o_valid_reg || (result.ready && last);
    assign rgb       = int_first ? mean_rgb : o_meta_reg.pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            sent_reg    <= 1'b0;
        end
        else if (adv)
        begin
            o_valid_reg <= meta_valid && (meta.int_v || meta.brd_v);
            sent_reg    <= 1'b0;
        end
        else if (result.ready)
        begin
            sent_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_meta_reg <= meta;
        end
    end

    assign result.valid       = o_valid_reg;
    assign result.out_column  = int_first ? o_meta_reg.col - OUT_COL_W'(HALF) : o_meta_reg.col;
    assign result.out_row     = int_first ? o_meta_reg.row - OUT_ROW_W'(HALF) : o_meta_reg.row;
    assign result.red_out     = rgb[7:0];
    assign result.green_out   = rgb[15:8];
    assign result.blue_out    = rgb[23:16];
    assign result.last_of_run = last;

endmodule

`default_nettype wire

>>> hdl/box_mean_filter.sv
// Channel  | Dir | Handshake   | Payload
// pixel    | in  | valid/ready | frame_start, red_in, green_in, blue_in
// result   | out | valid/ready | out_column, out_row, red/green/blue_out, last_of_run
// cfg      | in  | cfg_we      | cfg_index, cfg_data (0 image_width, 1 image_height)
//
// One pixel per clock while results are taken; a pixel that yields two results
// (interior then border) holds the input while the merge stage sends the second.
// Registered stages in order: line store read, column sums, window total, divide.
// rst_n is asynchronous; line stores and window sums need no clearing.
// A stalled result freezes the whole pipeline; the result register parts the sides.
`default_nettype none

module box_mean_filter #(
    parameter int WINDOW_SIZE = bmf_pkg::DEF_WINDOW_SIZE,
    parameter int MAX_WIDTH   = bmf_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [bmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bmf_pkg::CFG_DATA_W-1:0] cfg_data,
    bmf_pix_if.sink                             pixel,
    bmf_res_if.source                           result
);
    import bmf_pkg::*;

    localparam int HALF  = WINDOW_SIZE / 2;
    localparam int SPAN  = 2 * HALF + 1;
    localparam int LINES = SPAN - 1;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int LPW   = $clog2(LINES);
    localparam int RST_W = (RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM;
    localparam logic [IMG_H_W-1:0] MAXW_X = IMG_H_W'(MAX_WIDTH);
    localparam logic [IMG_H_W-1:0] MAXH_X = IMG_H_W'(MAX_HEIGHT);

    logic [CW:0]          width_reg;
    logic [IMG_H_W-1:0]   height_reg;
    logic [IMG_H_W-1:0]   wval;
    logic [IMG_H_W-1:0]   hval;

    // configuration, stored already clamped
    assign wval = IMG_H_W'(cfg_data[IMG_W_W-1:0]);
    assign hval = cfg_data[IMG_H_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= (CW+1)'(RST_W);
            height_reg <= IMG_H_W'(RESET_DIM);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    if (wval == '0)
                        width_reg <= (CW+1)'(1);
                    else if (wval > MAXW_X)
                        width_reg <= (CW+1)'(MAX_WIDTH);
                    else
                        width_reg <= (CW+1)'(wval);
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (hval == '0)
                        height_reg <= IMG_H_W'(1);
                    else if (hval > MAXH_X)
                        height_reg <= MAXH_X;
                    else
                        height_reg <= hval;
                end
                default:
                begin
                end
            endcase
        end
    end

    // position tracking
    logic              adv;
    logic              accept;
    logic [CW-1:0]     col_reg, col_next;
    logic [OUT_ROW_W-1:0] row_reg, row_next;
    logic [LPW-1:0]    lp_reg, lp_next;
    logic [CW:0]       c0, cn;
    logic [IMG_H_W-1:0] r0, rn;
    logic [LPW-1:0]    lp0;
    logic [CW-1:0]     col_s;
    logic [OUT_ROW_W-1:0] row_s;
    logic              int_s, brd_s;
    rgb_t              pix_s;

    assign accept      = pixel.valid && adv;
    assign pixel.ready = adv;
    assign pix_s       = {pixel.blue_in, pixel.green_in, pixel.red_in};

    function automatic logic [LPW-1:0] lp_inc(input logic [LPW-1:0] lp);
        return (lp == LPW'(LINES - 1)) ? '0 : lp + 1'b1;
    endfunction

    always_comb
    begin
        c0  = pixel.frame_start ? '0 : {1'b0, col_reg};
        r0  = pixel.frame_start ? '0 : {1'b0, row_reg};
        lp0 = pixel.frame_start ? '0 : lp_reg;
        if (c0 >= width_reg)
        begin
            c0  = '0;
            r0  = r0 + 1'b1;
            lp0 = lp_inc(lp0);
        end
        if (r0 >= height_reg)
        begin
            r0  = '0;
            lp0 = '0;
        end
        col_s = c0[CW-1:0];
        row_s = r0[OUT_ROW_W-1:0];

        cn = {1'b0, col_s} + 1'b1;
        rn = {1'b0, row_s} + 1'b1;
        col_next = cn[CW-1:0];
        row_next = row_s;
        lp_next  = lp0;
        if (cn >= width_reg)
        begin
            col_next = '0;
            if (rn >= height_reg)
            begin
                row_next = '0;
                lp_next  = '0;
            end
            else
            begin
                row_next = rn[OUT_ROW_W-1:0];
                lp_next  = lp_inc(lp0);
            end
        end

        int_s = (col_s >= CW'(2 * HALF)) && (row_s >= OUT_ROW_W'(2 * HALF));
        brd_s = (col_s < CW'(HALF)) || (({1'b0, col_s} + (CW+1)'(HALF)) >= width_reg)
             || (row_s < OUT_ROW_W'(HALF))
             || (({1'b0, row_s} + IMG_H_W'(HALF)) >= height_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            lp_reg  <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            lp_reg  <= lp_next;
        end
    end

    // line stores
    rgb_t rd [LINES];

    for (genvar i = 0; i < LINES; i++)
    begin : g_line
        bmf_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .clk   (clk),
            .we    (accept && (lp0 == LPW'(i))),
            .waddr (col_s),
            .wdata (pix_s),
            .re    (adv),
            .raddr (col_s),
            .rdata (rd[i])
        );
    end

    // pipeline control
    logic      a_valid_reg, b_valid_reg, c_valid_reg;
    bmf_meta_t a_meta_reg, b_meta_reg, c_meta_reg;
    bmf_meta_t meta_s;
    logic [LPW-1:0] a_lp_reg;

    assign meta_s = '{int_v: int_s, brd_v: brd_s, col: OUT_COL_W'(col_s), row: row_s,
                      pix: pix_s};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_meta_reg <= meta_s;
            a_lp_reg   <= lp0;
            b_meta_reg <= a_meta_reg;
            c_meta_reg <= b_meta_reg;
        end
    end

    // new window column, oldest row first
    rgb_t col_px [SPAN];
    logic [LPW:0] idx [LINES];

    always_comb
    begin
        for (int k = 0; k < LINES; k++)
        begin
            idx[k] = {1'b0, a_lp_reg} + (LPW+1)'(k);
            if (idx[k] >= (LPW+1)'(LINES))
                idx[k] = idx[k] - (LPW+1)'(LINES);
            col_px[k] = rd[idx[k][LPW-1:0]];
        end
        col_px[LINES] = a_meta_reg.pix;
    end

    // channel lanes
    logic [2:0][7:0] mean;

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_lane
        logic [SPAN-1:0][7:0] column;

        always_comb
        begin
            for (int k = 0; k < SPAN; k++)
            begin
                column[k] = col_px[k][8*ch +: 8];
            end
        end

        bmf_lane #(
            .WINDOW_SIZE (WINDOW_SIZE)
        ) u_lane (
            .clk    (clk),
            .adv    (adv),
            .shift  (adv && a_valid_reg),
            .column (column),
            .mean   (mean[ch])
        );
    end

    bmf_out #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .meta       (c_meta_reg),
        .meta_valid (c_valid_reg),
        .mean_rgb   (mean),
        .adv        (adv),
        .result     (result)
    );

endmodule

`default_nettype wire

>>> hdl/bmf_checker.sv
// Port-level checks for box_mean_filter, attached by bind.
// Depends on box_mean_filter and its stream interfaces.
`default_nettype none

module bmf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pix_ready,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic        res_last,
    input wire logic [9:0]  res_column,
    input wire logic [11:0] res_row
);

    // stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_column) && $stable(res_row))
        else $error("result position changed while stalled");

    // first of a pair blocks input and is followed by the closing result
    a_pair_block: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |-> !pix_ready)
        else $error("input taken while a pair is half sent");

    a_pair_close: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |=> res_valid && res_last)
        else $error("pair not closed by last result");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> pix_ready)
        else $error("input blocked with empty output");

endmodule

bind box_mean_filter bmf_checker u_bmf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_ready  (pixel.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_last   (result.last_of_run),
    .res_column (result.out_column),
    .res_row    (result.out_row)
);

`default_nettype wire
